### hdl/nsq_pkg.sv
// shared types and constants for the newton square root unit
`default_nettype none
package nsq_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 31;
  localparam int TOL_W     = 16;
  localparam int STEP_W    = 7;
  localparam int MAX_STEPS = 64;

  // dividend is operand * 2^FRAC_BITS, one quotient bit per cycle
  localparam int DVD_W     = DATA_W + FRAC_BITS;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] ONE_FX = {{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS;

  localparam int CFG_W      = TOL_W;
  localparam int CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER  = 1'b1;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
    logic set_limit;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic div_last;
    logic tol_pass;
    logic limit_reached;
  } sts_t;

endpackage
`default_nettype wire

### hdl/nsq_ctrl.sv
// controller state machine sequencing the newton steps
`default_nettype none
module nsq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire nsq_pkg::sts_t sts,
  output nsq_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CLASSIFY = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_UPDATE   = 3'd3;
  localparam logic [2:0] S_CHECK    = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLASSIFY;
        end
      end
      S_CLASSIFY: begin
        if (sts.special) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        // tolerance wins over the limit on the same step
        if (sts.tol_pass) begin
          state_nxt = S_FINISH;
        end else if (sts.limit_reached) begin
          cmd.set_limit = 1'b1;
          state_nxt     = S_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.result_load = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/nsq_dpath.sv
// datapath: config registers, radix-2 divider, estimate update and result register
`default_nettype none
module nsq_dpath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_wr_en,
  input  wire logic [nsq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [nsq_pkg::CFG_W-1:0]          cfg_wdata,
  input  wire logic [nsq_pkg::DATA_W-1:0]         in_operand,
  input  wire nsq_pkg::cmd_t                      cmd,
  output nsq_pkg::sts_t                           sts,
  output logic [nsq_pkg::DATA_W-1:0]              out_root,
  output logic                                    out_in_range,
  output logic [nsq_pkg::STEP_W-1:0]              out_steps_used,
  output logic                                    out_limit_hit
);

  localparam int DW = nsq_pkg::DATA_W;
  localparam int SW = nsq_pkg::STEP_W;

  logic [nsq_pkg::TOL_W-1:0] tol_r;
  logic [SW-1:0]             max_iter_r;

  logic [DW-1:0]                opnd_r;
  logic [DW-1:0]                est_r;
  logic [DW-1:0]                prev_r;
  logic [SW-1:0]                step_r;
  logic [SW-1:0]                limit_r;
  logic                         lim_hit_r;
  logic [DW-2:0]                rem_r;
  logic [nsq_pkg::DVD_W-1:0]    dvd_r;
  logic [DW-1:0]                quo_r;
  logic [nsq_pkg::CNT_W-1:0]    cnt_r;

  logic [DW-1:0] root_r;
  logic          in_range_r;
  logic [SW-1:0] steps_r;
  logic          lim_out_r;

  logic [SW-1:0] limit_nxt;
  logic [DW-1:0] trial;
  logic          qbit;
  logic [DW:0]   sum;
  logic [DW-1:0] diff;
  logic          out_of_range;
  logic          trivial;
  logic [DW-1:0] root_nxt;

  // step limit clamped to 1..64
  always_comb begin
    if (max_iter_r == '0) begin
      limit_nxt = SW'(1);
    end else if (max_iter_r > SW'(nsq_pkg::MAX_STEPS)) begin
      limit_nxt = SW'(nsq_pkg::MAX_STEPS);
    end else begin
      limit_nxt = max_iter_r;
    end
  end

  // remainder stays below the divisor, which never exceeds 1.0
  assign trial = {rem_r, dvd_r[nsq_pkg::DVD_W-1]};
  assign qbit  = (trial >= est_r);
  assign sum   = {1'b0, est_r} + {1'b0, quo_r};
  assign diff  = (prev_r >= est_r) ? (prev_r - est_r) : (est_r - prev_r);

  assign out_of_range = (opnd_r > nsq_pkg::ONE_FX);
  assign trivial      = (opnd_r == '0) || (opnd_r == nsq_pkg::ONE_FX);

  assign sts.special       = out_of_range || trivial;
  assign sts.div_last      = (cnt_r == nsq_pkg::CNT_W'(nsq_pkg::DIV_STEPS - 1));
  assign sts.tol_pass      = (diff < DW'(tol_r));
  assign sts.limit_reached = (step_r >= limit_r);

  always_comb begin
    if (out_of_range) begin
      root_nxt = '0;
    end else if (trivial) begin
      root_nxt = opnd_r;
    end else begin
      root_nxt = est_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r      <= nsq_pkg::TOL_W'(2);
      max_iter_r <= SW'(40);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nsq_pkg::REG_TOLERANCE: tol_r      <= cfg_wdata;
        nsq_pkg::REG_MAX_ITER:  max_iter_r <= cfg_wdata[SW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      opnd_r    <= in_operand;
      est_r     <= nsq_pkg::ONE_FX;
      prev_r    <= '0;
      step_r    <= '0;
      limit_r   <= limit_nxt;
      lim_hit_r <= 1'b0;
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      dvd_r <= {opnd_r, {nsq_pkg::FRAC_BITS{1'b0}}};
      quo_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= qbit ? (DW-1)'(trial - est_r) : trial[DW-2:0];
      dvd_r <= {dvd_r[nsq_pkg::DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DW-2:0], qbit};
      cnt_r <= cnt_r + nsq_pkg::CNT_W'(1);
    end
    if (cmd.update) begin
      prev_r <= est_r;
      est_r  <= sum[DW:1];
      step_r <= step_r + SW'(1);
    end
    if (cmd.set_limit) begin
      lim_hit_r <= 1'b1;
    end
    if (cmd.result_load) begin
      root_r     <= root_nxt;
      in_range_r <= !out_of_range;
      steps_r    <= step_r;
      lim_out_r  <= lim_hit_r;
    end
  end

  assign out_root       = root_r;
  assign out_in_range   = in_range_r;
  assign out_steps_used = steps_r;
  assign out_limit_hit  = lim_out_r;

endmodule
`default_nettype wire

### hdl/newton_sqrt_unit_interval.sv
// operands 0, 1.0 and out-of-range skip the divider; others run steps_used newton steps
// each newton step is a full pass of the bit-serial divider plus update and check
// throughput: one beat in flight; the next operand is taken once the result is
// registered, while that result may still wait on out_ready
// reset: synchronous active-low rst_n clears control state and restores
// tolerance_lsb to 2 and max_iterations to 40
`default_nettype none
module newton_sqrt_unit_interval (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [nsq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nsq_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [nsq_pkg::DATA_W-1:0]    in_operand,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [nsq_pkg::DATA_W-1:0]         out_root,
  output logic                               out_in_range,
  output logic [nsq_pkg::STEP_W-1:0]         out_steps_used,
  output logic                               out_limit_hit
);

  nsq_pkg::cmd_t cmd;
  nsq_pkg::sts_t sts;

  nsq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  nsq_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_operand     (in_operand),
    .cmd            (cmd),
    .sts            (sts),
    .out_root       (out_root),
    .out_in_range   (out_in_range),
    .out_steps_used (out_steps_used),
    .out_limit_hit  (out_limit_hit)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again right after a beat");

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_steps_used <= nsq_pkg::STEP_W'(nsq_pkg::MAX_STEPS))
    else $error("steps_used above the step ceiling");

  a_out_of_range_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |->
      out_root == '0 && out_steps_used == '0 && !out_limit_hit)
    else $error("out-of-range result not cleared");

  a_limit_needs_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_limit_hit |-> out_steps_used != '0 && out_in_range)
    else $error("limit flag without any newton step");

endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the newton square root unit: directed table, tolerance/limit ties, then random phases
`timescale 1ns / 100ps
module tb;

  localparam int DATA_W    = nsq_pkg::DATA_W;
  localparam int FRAC_BITS = nsq_pkg::FRAC_BITS;
  localparam int TOL_W     = nsq_pkg::TOL_W;
  localparam int STEP_W    = nsq_pkg::STEP_W;
  localparam int MAX_STEPS = nsq_pkg::MAX_STEPS;
  localparam int CFG_W     = nsq_pkg::CFG_W;
  localparam int CFG_IDX_W = nsq_pkg::CFG_IDX_W;

  localparam logic [DATA_W-1:0] UNIT = nsq_pkg::ONE_FX;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int DRAIN_CYCLES = 100;
  localparam int N_DIRECTED = 20;
  localparam int N_PHASES = 14;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    logic [DATA_W-1:0] root;
    logic              in_range;
    logic [STEP_W-1:0] steps_used;
    logic              limit_hit;
  } sqrt_result_t;

  typedef struct packed {
    logic [DATA_W-1:0] operand;
    logic [TOL_W-1:0]  tol;
    logic [STEP_W-1:0] max_iter;
    logic              known;
    logic [DATA_W-1:0] want_root;
    logic              want_in_range;
    logic [STEP_W-1:0] want_steps;
    logic              want_limit;
  } sqrt_case_t;

  // rows with known set carry a hand-read answer, the rest go to the predictor
  localparam sqrt_case_t DIRECTED [N_DIRECTED] = '{
    '{32'h0000_0000, 16'd2,     7'd40,  1'b1, 32'h0000_0000, 1'b1, 7'd0, 1'b0},
    '{32'h8000_0000, 16'd2,     7'd40,  1'b1, 32'h8000_0000, 1'b1, 7'd0, 1'b0},
    '{32'h8000_0001, 16'd2,     7'd40,  1'b1, 32'h0000_0000, 1'b0, 7'd0, 1'b0},
    '{32'hFFFF_FFFF, 16'd2,     7'd40,  1'b1, 32'h0000_0000, 1'b0, 7'd0, 1'b0},
    '{32'hAAAA_AAAA, 16'd2,     7'd40,  1'b1, 32'h0000_0000, 1'b0, 7'd0, 1'b0},
    '{32'h0000_0001, 16'd2,     7'd40,  1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h7FFF_FFFF, 16'd2,     7'd40,  1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h4000_0000, 16'd2,     7'd40,  1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h2000_0000, 16'd2,     7'd40,  1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h5555_5555, 16'd2,     7'd40,  1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h4000_0000, 16'd0,     7'd5,   1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h0000_0001, 16'd0,     7'd5,   1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h1234_5678, 16'd0,     7'd1,   1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h4000_0000, 16'd0,     7'd0,   1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h0000_0001, 16'd0,     7'd127, 1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h0000_0000, 16'd0,     7'd127, 1'b1, 32'h0000_0000, 1'b1, 7'd0, 1'b0},
    '{32'h8000_0000, 16'd0,     7'd127, 1'b1, 32'h8000_0000, 1'b1, 7'd0, 1'b0},
    '{32'h4000_0000, 16'd65535, 7'd64,  1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h0000_0001, 16'd65535, 7'd64,  1'b0, 32'h0, 1'b0, 7'd0, 1'b0},
    '{32'h3000_0000, 16'd1,     7'd64,  1'b0, 32'h0, 1'b0, 7'd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [DATA_W-1:0] in_operand;
  logic out_valid;
  logic out_ready;
  logic [DATA_W-1:0] out_root;
  logic out_in_range;
  logic [STEP_W-1:0] out_steps_used;
  logic out_limit_hit;

  // register copies kept in step with every write
  logic [TOL_W-1:0] tol_shadow = 16'd2;
  logic [STEP_W-1:0] max_iter_shadow = 7'd40;

  sqrt_result_t expected_roots[$];
  int mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit quiet = 1'b0;
  int stall_odds = 0;
  int stall_left = 0;

  newton_sqrt_unit_interval dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operand     (in_operand),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_root       (out_root),
    .out_in_range   (out_in_range),
    .out_steps_used (out_steps_used),
    .out_limit_hit  (out_limit_hit)
  );

  always #10 clk = ~clk;

  // floor(num * 2^FRAC_BITS / den) by restoring long division, saturating
  function automatic logic [63:0] scaled_quotient(logic [DATA_W-1:0] num, logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    logic sat;
    logic top;
    logic qbit;
    logic bit_in;
    if (den == 64'd0) return '1;
    rem = '0;
    quo = '0;
    sat = 1'b0;
    for (int i = 0; i < DATA_W + FRAC_BITS; i++) begin
      bit_in = (i < DATA_W) ? num[DATA_W-1-i] : 1'b0;
      top = rem[63];
      rem = {rem[62:0], bit_in};
      qbit = 1'b0;
      if (top || rem >= den) begin
        rem = rem - den;
        qbit = 1'b1;
      end
      if (quo[63]) sat = 1'b1;
      quo = {quo[62:0], qbit};
    end
    return sat ? '1 : quo;
  endfunction

  function automatic sqrt_result_t predict_root(logic [DATA_W-1:0] operand,
                                                logic [TOL_W-1:0] tol,
                                                logic [STEP_W-1:0] max_iter);
    sqrt_result_t r;
    logic [63:0] est;
    logic [63:0] prev;
    logic [63:0] q;
    logic [63:0] s;
    logic [63:0] diff;
    int unsigned limit;
    int unsigned steps;
    r = '0;
    steps = 0;
    limit = 32'(max_iter);
    if (limit == 0) limit = 1;
    if (limit > MAX_STEPS) limit = MAX_STEPS;
    est = 64'(UNIT);
    if (operand <= UNIT) begin
      r.in_range = 1'b1;
      if (operand == '0 || operand == UNIT) begin
        r.root = operand;
      end else begin
        do begin
          prev = est;
          q = scaled_quotient(operand, est);
          s = est + q;
          if (s < est) s = '1;
          est = s >> 1;
          steps++;
          diff = (prev >= est) ? prev - est : est - prev;
          if (diff < 64'(tol)) break;
          if (steps >= limit) begin
            r.limit_hit = 1'b1;
            break;
          end
        end while (1'b1);
        r.root = est[DATA_W-1:0];
      end
    end
    r.steps_used = steps[STEP_W-1:0];
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_operand();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: begin
        v = $urandom() | UNIT;
        if (v == UNIT) v = '1;
      end
      1: v = $urandom_range(0, 1) ? UNIT : '0;
      2, 3, 4: v = $urandom() >> $urandom_range(1, 31);
      5: v = UNIT - $urandom_range(1, 1000);
      default: v = $urandom_range(1, 32'h7FFF_FFFF);
    endcase
    return v;
  endfunction

  // both registers in back-to-back cycles, called at a falling edge while idle
  task automatic apply_config(input logic [TOL_W-1:0] tol, input logic [STEP_W-1:0] max_iter);
    cfg_wr_en <= 1'b1;
    cfg_index <= nsq_pkg::REG_TOLERANCE;
    cfg_wdata <= tol;
    @(negedge clk);
    cfg_index <= nsq_pkg::REG_MAX_ITER;
    cfg_wdata <= CFG_W'(max_iter);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tol_shadow = tol;
    max_iter_shadow = max_iter;
  endtask

  // hold off input until every outstanding result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_roots.size() != 0) @(negedge clk);
  endtask

  task automatic send_operand(input logic [DATA_W-1:0] operand, input sqrt_result_t want);
    if (!quiet && stall_odds != 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operand <= operand;
    do @(posedge clk); while (!in_ready);
    expected_roots.push_back(want);
    @(negedge clk);
  endtask

  // result side stalls in bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && stall_odds != 0 && $urandom_range(0, 8 * stall_odds - 1) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 18) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sqrt_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_roots.size() == 0) begin
        $error("result beat with nothing expected: root %h", out_root);
        mismatch_count++;
      end else begin
        want = expected_roots.pop_front();
        if (out_root !== want.root) begin
          $error("root: expected %h, got %h", want.root, out_root);
          mismatch_count++;
        end
        if (out_in_range !== want.in_range) begin
          $error("in_range: expected %0d, got %0d", want.in_range, out_in_range);
          mismatch_count++;
        end
        if (out_steps_used !== want.steps_used) begin
          $error("steps_used: expected %0d, got %0d", want.steps_used, out_steps_used);
          mismatch_count++;
        end
        if (out_limit_hit !== want.limit_hit) begin
          $error("limit_hit: expected %0d, got %0d", want.limit_hit, out_limit_hit);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    sqrt_case_t row;
    sqrt_result_t want;
    logic [DATA_W-1:0] tie_ops [4];
    logic [TOL_W-1:0] tol;
    logic [STEP_W-1:0] max_iter;
    tie_ops = '{32'h0000_1000, 32'h1234_5678, 32'h0000_0003, 32'h6000_0000};
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = nsq_pkg::REG_TOLERANCE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_operand = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    stall_odds = 2;
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.tol != tol_shadow || row.max_iter != max_iter_shadow) begin
        settle();
        apply_config(row.tol, row.max_iter);
      end
      if (row.known)
        want = '{row.want_root, row.want_in_range, row.want_steps, row.want_limit};
      else
        want = predict_root(row.operand, tol_shadow, max_iter_shadow);
      send_operand(row.operand, want);
    end

    // step limit set to exactly the step at which the tolerance test passes
    foreach (tie_ops[k]) begin
      settle();
      want = predict_root(tie_ops[k], 16'd2, 7'(MAX_STEPS));
      apply_config(16'd2, want.steps_used);
      send_operand(tie_ops[k], predict_root(tie_ops[k], tol_shadow, max_iter_shadow));
    end

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case ($urandom_range(0, 5))
        0: tol = '0;
        1: tol = 16'd1;
        2: tol = 16'd2;
        3: tol = 16'($urandom_range(0, 16));
        4: tol = 16'($urandom_range(0, 65535));
        default: tol = 16'hFFFF;
      endcase
      // zero tolerance always runs to the limit, so keep that limit low
      if (tol == '0) begin
        max_iter = 7'($urandom_range(0, 8));
      end else begin
        case ($urandom_range(0, 7))
          0: max_iter = '0;
          1: max_iter = 7'($urandom_range(65, 127));
          2: max_iter = 7'(MAX_STEPS);
          3: max_iter = 7'd1;
          default: max_iter = 7'($urandom_range(1, 64));
        endcase
      end
      apply_config(tol, max_iter);
      quiet = (p >= N_PHASES - 2);
      stall_odds = $urandom_range(0, 3);
      repeat (PHASE_ITEMS) begin
        row.operand = random_operand();
        send_operand(row.operand, predict_root(row.operand, tol_shadow, max_iter_shadow));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
